// File: hdl/tpa_pkg.sv
package tpa_pkg;

  // Field widths of one beat on either side
  localparam int unsigned POS_W        = 32;
  localparam int unsigned LIGHT_W      = 5;
  localparam int unsigned TEX_W        = 16;
  localparam int unsigned PTYPE_W      = 3;
  localparam int unsigned CORNER_W     = 2;
  localparam int unsigned ATTR_W       = LIGHT_W + 2 * TEX_W;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned NUM_SLOTS       = 3;
  localparam int unsigned SLOT_IDX_W      = $clog2(NUM_SLOTS);
  localparam int unsigned Q_DEPTH         = 2;

  // Item kinds
  localparam logic MODE_BEGIN  = 1'b0;
  localparam logic MODE_VERTEX = 1'b1;

  // Primitive type codes on a begin beat
  localparam logic [PTYPE_W-1:0] PRIM_TRIS  = 3'd0;
  localparam logic [PTYPE_W-1:0] PRIM_FAN   = 3'd1;
  localparam logic [PTYPE_W-1:0] PRIM_QUADS = 3'd2;
  localparam logic [PTYPE_W-1:0] PRIM_STRIP = 3'd3;

  // Corner numbers within a triangle
  localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd2;

  typedef enum logic [1:0] {
    KIND_TRIS,
    KIND_FAN,
    KIND_STRIP,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    logic                     mode;
    logic [PTYPE_W-1:0]       prim_type;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_z;
    logic [LIGHT_W-1:0]       light_level;
    logic signed [TEX_W-1:0]  tex_s;
    logic signed [TEX_W-1:0]  tex_t;
  } in_item_t;

  typedef struct packed {
    logic [CORNER_W-1:0]      corner;
    logic                     last;
    logic [POS_W-1:0]         out_x;
    logic [POS_W-1:0]         out_y;
    logic [POS_W-1:0]         out_z;
    logic [LIGHT_W-1:0]       out_light;
    logic signed [TEX_W-1:0]  out_s;
    logic signed [TEX_W-1:0]  out_t;
  } out_item_t;

endpackage

// File: hdl/tpa_front.sv
module tpa_front #(
  parameter int unsigned COORD_WIDTH = tpa_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  tpa_pkg::in_item_t   in_item,
  output logic                q_push,
  input  logic                q_full,
  output logic [3*(3*COORD_WIDTH+tpa_pkg::ATTR_W)-1:0] q_data
);
  import tpa_pkg::*;

  localparam int unsigned VW = 3 * COORD_WIDTH + ATTR_W;

  kind_t                 kind_r, kind_nxt;
  logic [1:0]            fill_r, fill_nxt;
  logic [SLOT_IDX_W-1:0] ring_r, ring_nxt;
  logic                  parity_r, parity_nxt;
  logic [VW-1:0]         slot_r [NUM_SLOTS];

  logic                  accept;
  logic [VW-1:0]         vert;
  logic [VW-1:0]         view [NUM_SLOTS];
  logic                  wr_en;
  logic [SLOT_IDX_W-1:0] wr_idx;
  logic [SLOT_IDX_W-1:0] fill_idx;
  logic                  emit;
  logic                  rev;
  logic                  fan_copy;
  kind_t                 begin_kind;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign vert = {COORD_WIDTH'(in_item.pos_x), COORD_WIDTH'(in_item.pos_y),
                 COORD_WIDTH'(in_item.pos_z), in_item.light_level,
                 in_item.tex_s, in_item.tex_t};

  // Counter of three can only read three in a strip; clamp anyway
  assign fill_idx = (fill_r == 2'd3) ? SLOT_IDX_W'(NUM_SLOTS - 1) : SLOT_IDX_W'(fill_r);

  always_comb begin
    unique case (in_item.prim_type) inside
      PRIM_TRIS:              begin_kind = KIND_TRIS;
      PRIM_FAN, PRIM_QUADS:   begin_kind = KIND_FAN;
      PRIM_STRIP:             begin_kind = KIND_STRIP;
      default:                begin_kind = KIND_OTHER;
    endcase
  end

  always_comb begin
    kind_nxt   = kind_r;
    fill_nxt   = fill_r;
    ring_nxt   = ring_r;
    parity_nxt = parity_r;
    wr_en      = 1'b0;
    wr_idx     = fill_idx;
    emit       = 1'b0;
    rev        = 1'b0;
    fan_copy   = 1'b0;
    if (accept) begin
      if (in_item.mode == MODE_BEGIN) begin
        kind_nxt   = begin_kind;
        fill_nxt   = 2'd0;
        ring_nxt   = '0;
        parity_nxt = 1'b0;
      end else begin
        unique case (kind_r)
          KIND_TRIS: begin
            wr_en = 1'b1;
            if (fill_r == 2'd2) begin
              emit     = 1'b1;
              fill_nxt = 2'd0;
            end else begin
              fill_nxt = fill_r + 2'd1;
            end
          end
          KIND_FAN: begin
            wr_en = 1'b1;
            if (fill_r == 2'd2) begin
              emit     = 1'b1;
              fan_copy = 1'b1;
              fill_nxt = 2'd2;
            end else begin
              fill_nxt = fill_r + 2'd1;
            end
          end
          KIND_STRIP: begin
            wr_en      = 1'b1;
            wr_idx     = ring_r;
            ring_nxt   = (ring_r == SLOT_IDX_W'(NUM_SLOTS - 1)) ? '0 : ring_r + 1'b1;
            parity_nxt = ~parity_r;
            fill_nxt   = (fill_r == 2'd3) ? 2'd3 : fill_r + 2'd1;
            emit       = (fill_nxt == 2'd3);
            rev        = !parity_nxt;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Slot contents as they stand after this vertex is written
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      view[i] = (wr_en && wr_idx == SLOT_IDX_W'(i)) ? vert : slot_r[i];
    end
  end

  // Corner 0 in the low part; even strip counts swap the outer corners
  assign q_data = rev ? {view[0], view[1], view[2]} : {view[2], view[1], view[0]};
  assign q_push = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_TRIS;
      fill_r   <= 2'd0;
      ring_r   <= '0;
      parity_r <= 1'b0;
    end else begin
      kind_r   <= kind_nxt;
      fill_r   <= fill_nxt;
      ring_r   <= ring_nxt;
      parity_r <= parity_nxt;
    end
  end

  // Fan: the newest vertex also becomes the middle corner
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if ((wr_en && wr_idx == SLOT_IDX_W'(i)) || (fan_copy && i == 1)) begin
        slot_r[i] <= vert;
      end
    end
  end

endmodule

// File: hdl/tpa_queue.sv
module tpa_queue #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import tpa_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/tpa_back.sv
module tpa_back #(
  parameter int unsigned COORD_WIDTH = tpa_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [3*(3*COORD_WIDTH+tpa_pkg::ATTR_W)-1:0] q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output tpa_pkg::out_item_t  out_item
);
  import tpa_pkg::*;

  localparam int unsigned VW = 3 * COORD_WIDTH + ATTR_W;

  logic [3*VW-1:0]     tri_r;
  logic                valid_r, valid_nxt;
  logic [CORNER_W-1:0] corner_r, corner_nxt;
  logic                load;
  logic                at_last;
  logic [VW-1:0]       sel;

  assign at_last = (corner_r == CORNER_LAST);
  assign load    = !q_empty && (!valid_r || (pop && at_last));
  assign q_pop   = load;
  assign empty   = !valid_r;

  always_comb begin
    valid_nxt  = valid_r;
    corner_nxt = corner_r;
    if (load) begin
      valid_nxt  = 1'b1;
      corner_nxt = CORNER_FIRST;
    end else if (pop && valid_r) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        corner_nxt = corner_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      corner_r <= CORNER_FIRST;
    end else begin
      valid_r  <= valid_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tri_r <= q_data;
    end
  end

  always_comb begin
    case (corner_r)
      2'd0:    sel = tri_r[0 +: VW];
      2'd1:    sel = tri_r[VW +: VW];
      default: sel = tri_r[2*VW +: VW];
    endcase
  end

  always_comb begin
    out_item.corner    = corner_r;
    out_item.last      = at_last;
    out_item.out_x     = POS_W'(sel[ATTR_W + 2*COORD_WIDTH +: COORD_WIDTH]);
    out_item.out_y     = POS_W'(sel[ATTR_W + COORD_WIDTH +: COORD_WIDTH]);
    out_item.out_z     = POS_W'(sel[ATTR_W +: COORD_WIDTH]);
    out_item.out_light = sel[2*TEX_W +: LIGHT_W];
    out_item.out_s     = sel[TEX_W +: TEX_W];
    out_item.out_t     = sel[0 +: TEX_W];
  end

endmodule

// File: hdl/triangle_primitive_assembler.sv
// Triangle primitive assembler: groups a stream of vertices into triangles.
//
// Input channel: a beat is taken at a clock edge with push high and full low.
// A begin beat (mode 0) picks triangles, fan (quads act as a fan), strip or
// other, and clears the counters; a vertex beat (mode 1) lands in one of
// three slots (other drops it). Any beat that completes a triangle hands it
// to a two-entry triangle queue; the front keeps accepting beats as long as
// that queue has room, so begin beats and non-completing vertices are never
// held up by the result side unless both queue entries are taken.
// Result channel: a corner beat is on out_item while empty is low and is
// taken at an edge with pop high. Each triangle leaves as three corner beats
// (corner 0, 1, 2; last set on corner 2), one per cycle while pop stays high.
// The completing vertex's triangle is written into the queue, then loaded
// into the output stage when that stage is free, and shows its first corner.
// Throughput: one corner per cycle while pop stays high, so a strip or fan
// gives three corners per vertex; the output corner sequencer is the limit.
// Stall: with pop low the current corner holds, the queue fills, then full
// rises and input beats wait. Reset (rst_n low, synchronous) empties the
// queue and the output stage and selects triangle lists.
module triangle_primitive_assembler #(
  parameter int unsigned COORD_WIDTH = tpa_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  tpa_pkg::in_item_t   in_item,
  output logic                empty,
  input  logic                pop,
  output tpa_pkg::out_item_t  out_item
);
  import tpa_pkg::*;

  // One queue entry holds three full vertices
  localparam int unsigned TRI_W = 3 * (3 * COORD_WIDTH + ATTR_W);

  logic             q_push;
  logic             q_full;
  logic [TRI_W-1:0] q_wdata;
  logic             q_pop;
  logic             q_empty;
  logic [TRI_W-1:0] q_rdata;

  // Front: decode beats, track slots and counters, build whole triangles
  tpa_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  // Decouple the two sides: hold up to two finished triangles
  tpa_queue #(
    .WIDTH (TRI_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back: advance through the three corners of the held triangle
  tpa_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// File: hdl/tpa_checker.sv
module tpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input tpa_pkg::in_item_t   in_item,
  input logic                empty,
  input logic                pop,
  input tpa_pkg::out_item_t  out_item
);
  import tpa_pkg::*;

  // Reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result side not empty after reset");

  // A stalled corner beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled corner beat changed");

  // Last flag marks the third corner only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.last == (out_item.corner == CORNER_LAST)))
    else $error("last flag does not match corner");

  // Inside a triangle the next corner follows at once
  a_next_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_item.last) |=>
      (!empty && out_item.corner == CORNER_W'($past(out_item.corner) + 2'd1)))
    else $error("corner sequence broken");

  // A new triangle starts at its first corner
  a_first_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_item.last) |=> (empty || out_item.corner == CORNER_FIRST))
    else $error("triangle did not start at first corner");

endmodule

bind triangle_primitive_assembler tpa_checker u_tpa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .in_item  (in_item),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// File: bench/triangle_corner_checker.sv
module triangle_corner_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  tpa_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  tpa_pkg::out_item_t out_item,
  output int unsigned        mismatches,
  output int unsigned        corners_owed,
  output int unsigned        triangles_seen
);
  import tpa_pkg::*;

  logic [PTYPE_W-1:0] prim_sel;
  out_item_t          slot [NUM_SLOTS];
  logic [1:0]         filled;
  logic [1:0]         ring_pos;
  logic               odd_count;
  out_item_t          expected_corners [$];

  task automatic clear_assembly();
    prim_sel  = PRIM_TRIS;
    filled    = '0;
    ring_pos  = '0;
    odd_count = 1'b0;
    foreach (slot[i]) slot[i] = '0;
  endtask

  task automatic store_vertex(int idx, in_item_t v);
    slot[idx].out_x     = v.pos_x;
    slot[idx].out_y     = v.pos_y;
    slot[idx].out_z     = v.pos_z;
    slot[idx].out_light = v.light_level;
    slot[idx].out_s     = v.tex_s;
    slot[idx].out_t     = v.tex_t;
  endtask

  // Queue corners in slot order 0,1,2, or 2,1,0 when reversed.
  task automatic queue_triangle(bit reversed);
    out_item_t c;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      c        = slot[reversed ? NUM_SLOTS - 1 - k : k];
      c.corner = k[CORNER_W-1:0];
      c.last   = (c.corner == CORNER_LAST);
      expected_corners.push_back(c);
    end
  endtask

  task automatic assemble(in_item_t v);
    if (v.mode == MODE_BEGIN) begin
      prim_sel  = (v.prim_type == PRIM_QUADS) ? PRIM_FAN : v.prim_type;
      filled    = '0;
      ring_pos  = '0;
      odd_count = 1'b0;
    end else if (prim_sel == PRIM_TRIS || prim_sel == PRIM_FAN) begin
      store_vertex(int'(filled), v);
      filled = filled + 2'd1;
      if (filled == 2'd3) begin
        queue_triangle(1'b0);
        if (prim_sel == PRIM_FAN) begin
          slot[1] = slot[2];
          filled  = 2'd2;
        end else begin
          filled = '0;
        end
      end
    end else if (prim_sel == PRIM_STRIP) begin
      store_vertex(int'(ring_pos), v);
      ring_pos  = (ring_pos == 2'd2) ? 2'd0 : ring_pos + 2'd1;
      odd_count = ~odd_count;
      if (filled < 2'd3) filled = filled + 2'd1;
      if (filled == 2'd3) queue_triangle(!odd_count);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: corner %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_corner(out_item_t got);
    out_item_t want;
    if (expected_corners.size() == 0) begin
      $display("%0t: unexpected corner beat: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = expected_corners.pop_front();
      check_field("corner", 32'(want.corner), 32'(got.corner));
      check_field("last", 32'(want.last), 32'(got.last));
      check_field("x", want.out_x, got.out_x);
      check_field("y", want.out_y, got.out_y);
      check_field("z", want.out_z, got.out_z);
      check_field("light", 32'(want.out_light), 32'(got.out_light));
      check_field("s", 32'(want.out_s), 32'(got.out_s));
      check_field("t", 32'(want.out_t), 32'(got.out_t));
      if (got.last) triangles_seen++;
    end
  endtask

  initial begin
    mismatches     = 0;
    corners_owed   = 0;
    triangles_seen = 0;
    clear_assembly();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_assembly();
      expected_corners.delete();
    end else begin
      if (pop && !empty) check_corner(out_item);
      if (push && !full) assemble(in_item);
    end
    corners_owed = expected_corners.size();
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import tpa_pkg::*;

  // Codes past strip select "other": vertices are dropped.
  localparam logic [PTYPE_W-1:0] PRIM_OTHER    = 3'd4;
  localparam logic [PTYPE_W-1:0] PRIM_TOP_CODE = 3'd7;

  localparam int unsigned RANDOM_BEATS = 195;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  int unsigned mismatches;
  int unsigned corners_owed;
  int unsigned triangles_seen;

  int unsigned cycles;
  int unsigned begin_beats;
  int unsigned vertex_beats;
  int unsigned counted;
  int unsigned n_verts;
  int unsigned stall;
  int unsigned burst;
  int unsigned r;
  bit          steady;
  bit          dropping;
  logic [PTYPE_W-1:0] kind;

  triangle_primitive_assembler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  triangle_corner_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .mismatches     (mismatches),
    .corners_owed   (corners_owed),
    .triangles_seen (triangles_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Bound the run: a lost triangle or a stuck handshake ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d corners still owed", cycles, corners_owed);
      $display("FAIL triangle_primitive_assembler");
      $finish;
    end
  end

  // Mostly no gap or a short one, now and then a long one; none while steady.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (steady || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Bias position words toward all-zero and all-one patterns now and then.
  function automatic logic [POS_W-1:0] rand_word();
    int unsigned p;
    p = $urandom_range(0, 15);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return $urandom;
  endfunction

  function automatic in_item_t make_vertex();
    in_item_t v;
    v.mode        = MODE_VERTEX;
    v.prim_type   = PTYPE_W'($urandom_range(0, 7));
    v.pos_x       = rand_word();
    v.pos_y       = rand_word();
    v.pos_z       = rand_word();
    v.light_level = LIGHT_W'($urandom_range(0, 31));
    v.tex_s       = TEX_W'($urandom);
    v.tex_t       = TEX_W'($urandom);
    return v;
  endfunction

  function automatic in_item_t fixed_vertex(logic [POS_W-1:0] p, logic [LIGHT_W-1:0] l,
                                            logic [TEX_W-1:0] st);
    in_item_t v;
    v.mode        = MODE_VERTEX;
    v.prim_type   = PRIM_TOP_CODE;
    v.pos_x       = p;
    v.pos_y       = ~p;
    v.pos_z       = p ^ 32'h5a5a_a5a5;
    v.light_level = l;
    v.tex_s       = st;
    v.tex_t       = ~st;
    return v;
  endfunction

  // Junk in the vertex fields of a begin beat must be ignored.
  function automatic in_item_t make_begin(logic [PTYPE_W-1:0] p);
    in_item_t b;
    b           = make_vertex();
    b.mode      = MODE_BEGIN;
    b.prim_type = p;
    return b;
  endfunction

  // Drive one beat at the falling edge, hold it until taken, return at a falling edge.
  task automatic send(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
    if (it.mode == MODE_BEGIN) begin
      begin_beats++;
      dropping = (it.prim_type >= PRIM_OTHER);
    end else begin
      vertex_beats++;
    end
  endtask

  // Result side: random stalls, then bursts of pop.
  initial begin
    pop = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      burst = $urandom_range(1, 8);
      pop <= 1'b1;
      repeat (burst) @(negedge clk);
    end
  end

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    in_item = '0;
    steady  = 1'b0;
    dropping = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: triangle list straight out of reset, extreme field values.
    send(fixed_vertex('0, '0, 16'h8000));
    send(fixed_vertex('1, 5'd31, 16'h7fff));
    send(fixed_vertex(32'h8000_0001, 5'd16, 16'hffff));
    send(make_begin(PRIM_TRIS));
    repeat (3) send(make_vertex());
    // Quads behave as a fan: four vertices give two triangles.
    send(make_begin(PRIM_QUADS));
    repeat (4) send(make_vertex());
    send(make_begin(PRIM_FAN));
    repeat (3) send(make_vertex());
    // Strip: odd count in order, even count reversed.
    send(make_begin(PRIM_STRIP));
    repeat (4) send(make_vertex());
    // Other types drop vertices.
    send(make_begin(PRIM_OTHER));
    send(make_vertex());
    send(make_begin(PRIM_TOP_CODE));
    send(make_vertex());

    // Random: mostly well-formed primitives of random length, some bare vertices.
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      steady = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 22)      kind = PRIM_TRIS;
      else if (r < 44) kind = PRIM_FAN;
      else if (r < 56) kind = PRIM_QUADS;
      else if (r < 88) kind = PRIM_STRIP;
      else             kind = PTYPE_W'($urandom_range(4, 7));
      // Skip the begin now and then so vertices carry on the previous primitive.
      if ($urandom_range(0, 9) != 0) begin
        send(make_begin(kind));
        counted++;
      end
      n_verts = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 9) : $urandom_range(10, 24);
      repeat (n_verts) begin
        send(make_vertex());
        if (!dropping) counted++;
      end
    end
    push   <= 1'b0;
    steady = 1'b0;

    while (corners_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d begin and %0d vertex beats over list, fan, quad, strip and other types,",
             begin_beats, vertex_beats);
    $display("and checked %0d triangles corner by corner under random stalls.", triangles_seen);
    if (mismatches == 0) begin
      $display("PASS triangle_primitive_assembler");
    end else begin
      $display("FAIL triangle_primitive_assembler");
    end
    $finish;
  end

endmodule
